FILE: hdl/hsfc_pkg.sv
// hsfc_pkg: types and constants for the half/single float converter.
// No dependencies.
`timescale 1ns / 1ps
package hsfc_pkg;
    typedef enum logic {
        CMD_H2S = 1'b0,
        CMD_S2H = 1'b1
    } t_cmd;

    localparam logic [31:0] SGL_INF     = 32'h7F80_0000;
    localparam logic [31:0] HALF_CLAMP  = 32'h0F80_0000;
    localparam logic [31:0] TRUNC_MASK  = 32'hFFFF_F000;
    localparam logic [31:0] REBIAS      = 32'h3800_0000;
    localparam logic [15:0] HALF_NAN    = 16'h7FFF;
    localparam logic [15:0] HALF_INF    = 16'h7C00;
endpackage

FILE: hdl/half_single_float_converter.sv
// half_single_float_converter: binary16 <-> binary32 converter, three stages.
// Depends on hsfc_pkg.
`timescale 1ns / 1ps
// One transaction is accepted per clock (busy stays low); its result shows
// on o_result with o_valid once it has passed the three register stages:
// decode/classify, shift (normalize or denormalize with rounding), then
// round-add, clamp and pack. The receiver cannot stall, so nothing is held
// back.
module half_single_float_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [31:0] i_operand,
    output logic        o_valid,
    output logic [31:0] o_result
);
    // stage 1: classify
    logic        r_v1, r_cmd1, r_sgn1, r_spec1, r_big1, r_sub1;
    logic [31:0] r_a1;
    logic [4:0]  r_he1;
    logic [9:0]  r_hm1;
    logic [4:0]  r_s1;
    logic [23:0] r_sig1;
    // stage 2: shift
    logic        r_v2, r_cmd2, r_sgn2, r_spec2, r_big2;
    logic [31:0] r_u2;
    logic [31:0] r_h2s2;
    // stage 3: output
    logic        r_v3;
    logic [31:0] r_res3;

    logic [31:0] n_a;
    logic [7:0]  n_ex;
    logic [23:0] n_sig;
    logic [4:0]  n_s;
    logic        n_zero;

    assign busy = 1'b0;

    always_comb begin
        n_a    = {1'b0, i_operand[30:0]} & hsfc_pkg::TRUNC_MASK;
        n_ex   = n_a[30:23];
        n_sig  = (n_ex != 8'd0) ? {1'b1, n_a[22:0]} : {1'b0, n_a[22:0]};
        n_zero = 1'b0;
        n_s    = 5'd0;
        if (n_ex == 8'd0) begin
            n_zero = 1'b1;
        end else if (n_ex <= 8'd112) begin
            if (n_ex < 8'd89) n_zero = 1'b1;
            else n_s = 5'(8'd113 - n_ex);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_cmd1  <= i_command;
        r_sgn1  <= (i_command == hsfc_pkg::CMD_H2S) ? i_operand[15] : i_operand[31];
        r_spec1 <= ({1'b0, i_operand[30:0]} >= hsfc_pkg::SGL_INF);
        r_big1  <= ({1'b0, i_operand[30:0]} > hsfc_pkg::SGL_INF);
        r_a1    <= n_a;
        r_sub1  <= (n_ex <= 8'd112);
        r_sig1  <= n_zero ? 24'd0 : n_sig;
        r_s1    <= n_s;
        r_he1   <= i_operand[14:10];
        r_hm1   <= i_operand[9:0];
    end

    logic [23:0] n_q, n_rem, n_half;
    logic [31:0] n_u;
    logic [3:0]  n_p;
    logic [31:0] n_h2s;

    always_comb begin
        n_q    = r_sig1 >> r_s1;
        n_rem  = r_sig1 & ((24'd1 << r_s1) - 24'd1);
        n_half = (r_s1 == 5'd0) ? 24'd0 : (24'd1 << (r_s1 - 5'd1));
        if (!r_sub1) begin
            n_u = r_a1 - hsfc_pkg::REBIAS;
        end else begin
            n_u = {8'd0, n_q};
            if (r_s1 != 5'd0 && (n_rem > n_half || (n_rem == n_half && n_q[0])))
                n_u = n_u + 32'd1;
        end
        n_p = 4'd0;
        for (int k = 0; k < 10; k++) begin
            if (r_hm1[k]) n_p = 4'(k);
        end
        if (r_he1 == 5'd31) begin
            n_h2s = {1'b0, 8'hFF, r_hm1, 13'd0};
        end else if (r_he1 != 5'd0) begin
            n_h2s = {1'b0, 8'(r_he1) + 8'd112, r_hm1, 13'd0};
        end else if (r_hm1 == 10'd0) begin
            n_h2s = 32'd0;
        end else begin
            n_h2s = {1'b0, 8'(n_p) + 8'd103, 23'({r_hm1, 13'd0} << (4'd10 - n_p))};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd2  <= r_cmd1;
        r_sgn2  <= r_sgn1;
        r_spec2 <= r_spec1;
        r_big2  <= r_big1;
        r_u2    <= n_u;
        r_h2s2  <= n_h2s;
    end

    logic [31:0] n_ur;
    logic [15:0] n_hh;
    always_comb begin
        n_ur = r_u2 + 32'h0000_1000;
        if (n_ur > hsfc_pkg::HALF_CLAMP) n_ur = hsfc_pkg::HALF_CLAMP;
        if (r_spec2) n_hh = r_big2 ? hsfc_pkg::HALF_NAN : hsfc_pkg::HALF_INF;
        else n_hh = n_ur[28:13];
        n_hh = n_hh | {r_sgn2, 15'd0};
    end

    always_ff @(posedge i_clk) begin
        if (r_cmd2 == hsfc_pkg::CMD_H2S) r_res3 <= r_h2s2 | {r_sgn2, 31'd0};
        else r_res3 <= {16'd0, n_hh};
    end

    assign o_valid  = r_v3;
    assign o_result = r_res3;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start ##1 1'b1 ##1 1'b1 |=> o_valid) else $error("lost transaction");
    a_hi0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_cmd2 == hsfc_pkg::CMD_S2H) |=> o_result[31:16] == 16'd0)
        else $error("half result upper bits");
    a_busy: assert property (@(posedge i_clk) !busy) else $error("busy");
endmodule
